### rtl/integer_set_table_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the integer set table checker
// ---------------------------------------------------------------------------
`ifndef INTEGER_SET_TABLE_ASSERT_SVH
`define INTEGER_SET_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define IST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define IST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ist_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ist_pkg
// Types and constants shared by the integer set table and its checker.
// ---------------------------------------------------------------------------
package ist_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 7;
    localparam int VALUE_W  = 32;
    localparam int PICK_W   = 31;
    localparam int BIT_W    = $clog2(PICK_W);

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_MEMBER  = 2'd2,
        OP_EXTRACT = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode                    opcode;
        logic signed [VALUE_W-1:0]  value;
        logic        [PICK_W-1:0]   random_pick;
    } t_item;

    typedef struct packed {
        logic                       ok;
        logic                       table_full;
        logic signed [VALUE_W-1:0]  out_value;
        logic        [COUNT_W-1:0]  count;
        logic                       empty_res;
    } t_result;

endpackage

### rtl/integer_set_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// integer_set_table
// Set of distinct signed 32-bit integers in a table kept in insertion order.
// ---------------------------------------------------------------------------
// Usage:
//   Command port: a word on i_item is taken at a rising edge with start high
//   and busy low. Opcodes: add, remove, member test, extract (entry picked by
//   random_pick mod count, counted from the newest entry).
//   Result port: one word per command on o_result, valid for exactly one
//   cycle while o_done is high. The receiver cannot stall; results are
//   registered, so a new command may be taken in the cycle o_done shows.
//   Sequence: member/add scan the held entries, one entry per cycle. Remove
//   scans up to the match and then compacts, one entry moved per cycle.
//   Extract runs a bit-serial modulo over random_pick, reads the picked
//   entry, then compacts. The single table read port sets this pace; the
//   slowest command is an extract of the oldest entry.
//   Reset (synchronous, active low) empties the set; table contents are not
//   cleared since only entries below the count are ever read.
// ---------------------------------------------------------------------------
module integer_set_table (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  ist_pkg::t_item   i_item,
    output logic             o_done,
    output ist_pkg::t_result o_result
);

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,  // compare entries against the value
        S_MOD   = 6'b000100,  // restoring modulo, one pick bit per cycle
        S_EXR   = 6'b001000,  // read the extracted entry
        S_EXW   = 6'b010000,  // capture it
        S_SHIFT = 6'b100000   // compact: entry i+1 moves to i
    } t_state;

    localparam int IW = ist_pkg::IDX_W;
    localparam int CW = ist_pkg::CNT_W;

    // Table storage, one read and one write per cycle.
    logic [ist_pkg::VALUE_W-1:0] mem [ist_pkg::CAPACITY];

    t_state                      r_state, n_state;
    logic [CW-1:0]               r_held,  n_held;
    logic [CW-1:0]               r_idx,   n_idx;   // next read address
    logic [CW-1:0]               r_pidx,  n_pidx;  // address of the word in r_rdata
    logic                        r_pend,  n_pend;  // r_rdata holds a live word
    logic [ist_pkg::VALUE_W-1:0] r_rdata;
    ist_pkg::t_item              r_item,  n_item;
    logic [CW-1:0]               r_rem,   n_rem;
    logic [ist_pkg::BIT_W-1:0]   r_bit,   n_bit;
    logic [ist_pkg::VALUE_W-1:0] r_out,   n_out;
    ist_pkg::t_result            r_res,   n_res;
    logic                        r_done,  n_done;

    logic                        wr_en;
    logic [IW-1:0]               wr_addr;
    logic [ist_pkg::VALUE_W-1:0] wr_data;

    logic                        hit, issue;
    logic [CW:0]                 rem_sh;
    logic [CW:0]                 rem_sub;
    logic [CW-1:0]               rem_nx;
    logic                        fin;
    logic                        fin_ok, fin_full;
    logic [CW-1:0]               fin_cnt;

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    // Shared compare: entry word against the command value.
    assign hit   = r_pend && (r_rdata == r_item.value);
    assign issue = (r_idx < r_held);

    // Modulo step: shift in one pick bit, subtract held when it fits.
    assign rem_sh  = {r_rem, r_item.random_pick[r_bit]};
    assign rem_sub = rem_sh - {1'b0, r_held};
    assign rem_nx  = (rem_sh >= {1'b0, r_held}) ? rem_sub[CW-1:0] : rem_sh[CW-1:0];

    always_comb begin
        n_state  = r_state;
        n_held   = r_held;
        n_idx    = r_idx;
        n_pidx   = r_pidx;
        n_pend   = r_pend;
        n_item   = r_item;
        n_rem    = r_rem;
        n_bit    = r_bit;
        n_out    = r_out;
        wr_en    = 1'b0;
        wr_addr  = r_held[IW-1:0];
        wr_data  = r_item.value;
        fin      = 1'b0;
        fin_ok   = 1'b0;
        fin_full = 1'b0;
        fin_cnt  = r_held;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item = i_item;
                    n_idx  = '0;
                    n_pend = 1'b0;
                    n_out  = '0;
                    n_rem  = '0;
                    n_bit  = ist_pkg::BIT_W'(ist_pkg::PICK_W - 1);
                    if (i_item.opcode == ist_pkg::OP_EXTRACT) begin
                        if (r_held == '0) begin
                            fin = 1'b1;  // nothing to extract
                        end else begin
                            n_state = S_MOD;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_pend = issue;
                n_pidx = r_idx;
                if (issue) begin
                    n_idx = r_idx + CW'(1);
                end
                if (hit) begin
                    case (r_item.opcode)
                        ist_pkg::OP_REMOVE: begin
                            n_state = S_SHIFT;
                            n_idx   = r_pidx + CW'(1);
                            n_pend  = 1'b0;
                        end
                        ist_pkg::OP_MEMBER: begin
                            fin    = 1'b1;
                            fin_ok = 1'b1;
                        end
                        default: begin
                            fin = 1'b1;  // duplicate add
                        end
                    endcase
                end else if (!issue) begin
                    fin = 1'b1;
                    if (r_item.opcode == ist_pkg::OP_ADD) begin
                        if (r_held >= CW'(ist_pkg::CAPACITY)) begin
                            fin_full = 1'b1;
                        end else begin
                            wr_en   = 1'b1;
                            n_held  = r_held + CW'(1);
                            fin_ok  = 1'b1;
                            fin_cnt = r_held + CW'(1);
                        end
                    end
                end
            end
            S_MOD: begin
                n_rem = rem_nx;
                n_bit = r_bit - ist_pkg::BIT_W'(1);
                if (r_bit == '0) begin
                    // newest-first position to table index
                    n_idx   = r_held - CW'(1) - rem_nx;
                    n_state = S_EXR;
                end
            end
            S_EXR: begin
                n_state = S_EXW;
            end
            S_EXW: begin
                n_out   = r_rdata;
                n_idx   = r_idx + CW'(1);
                n_pend  = 1'b0;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = IW'(r_pidx - CW'(1));
                    wr_data = r_rdata;
                end
                n_pend = issue;
                n_pidx = r_idx;
                if (issue) begin
                    n_idx = r_idx + CW'(1);
                end else begin
                    n_held  = r_held - CW'(1);
                    fin     = 1'b1;
                    fin_ok  = 1'b1;
                    fin_cnt = r_held - CW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state = S_IDLE;
        end

        n_done             = fin;
        n_res              = r_res;
        if (fin) begin
            n_res.ok         = fin_ok;
            n_res.table_full = fin_full;
            n_res.out_value  = (r_state == S_SHIFT) ? n_out : '0;
            n_res.count      = ist_pkg::COUNT_W'(fin_cnt);
            n_res.empty_res  = (fin_cnt == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_pidx <= n_pidx;
        r_item <= n_item;
        r_rem  <= n_rem;
        r_bit  <= n_bit;
        r_out  <= n_out;
        r_res  <= n_res;
    end

    // Table port: registered read at r_idx, one write.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[r_idx[IW-1:0]];
    end

endmodule

### rtl/ist_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ist_checker
// Port-level checks on the integer set table result words.
// ---------------------------------------------------------------------------
`include "integer_set_table_assert.svh"

module ist_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input ist_pkg::t_result o_result
);

    // an extract on an empty set finishes at once: strobe instead of busy
    `IST_ASSERT_NEXT(a_accept_busy, start && !busy, busy || o_done, "accepted word did not raise busy")
    `IST_ASSERT_NOW(a_empty_flag, o_done, o_result.empty_res == (o_result.count == '0), "empty flag disagrees with count")
    `IST_ASSERT_NOW(a_full_refused, o_done && o_result.table_full, !o_result.ok && (o_result.count == ist_pkg::COUNT_W'(ist_pkg::CAPACITY)), "full refusal with wrong ok or count")
    `IST_ASSERT_NOW(a_value_ok, o_done && (o_result.out_value != '0), o_result.ok, "value returned by a failed word")

endmodule

bind integer_set_table ist_checker u_ist_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
